FILE: design/plfr_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// parameter list fetch core. No dependencies.
package plfr_pkg;

   // Missing-map geometry
   localparam int MAX_PARAMS = 1024;
   localparam int WORD_W     = 32;
   localparam int ROWS       = MAX_PARAMS / WORD_W;
   localparam int ROW_W      = $clog2(ROWS);
   localparam int BIT_W      = $clog2(WORD_W);
   localparam int IDX_W      = $clog2(MAX_PARAMS);
   localparam int CNT_W      = $clog2(MAX_PARAMS + 1);

   localparam logic [15:0] COUNT_UNKNOWN = 16'hFFFF;

   // Input modes
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_VALUE = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   // Request kinds
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_LIST = 2'd1;
   localparam logic [1:0] KIND_ONE  = 2'd2;

   // Phases
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_LIST    = 2'd1;
   localparam logic [1:0] PH_RECV    = 2'd2;
   localparam logic [1:0] PH_RECV_TO = 2'd3;

   // Register file
   localparam int          ADDR_W            = 3;
   localparam logic        REG_RETRY_LIMIT   = 1'b0;
   localparam logic        REG_TIMEOUT_TICKS = 1'b1;
   localparam logic [3:0]  RETRY_LIMIT_RESET = 4'd3;
   localparam logic [31:0] TIMEOUT_RESET     = 32'd1000000;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_CLR_MAP,
      DP_FILL_INIT,
      DP_FILL_STEP,
      DP_LOW_RD,
      DP_LOW_FIN,
      DP_CLR_RD,
      DP_CLR_WR
   } dp_op_type;

   typedef enum logic [1:0] {
      TMR_HOLD,
      TMR_RESTART,
      TMR_DEC,
      TMR_STOP
   } tmr_op_type;

   typedef struct packed {
      logic       load;     // capture index/count of an accepted transaction
      dp_op_type  op;
      logic       sel_low;  // clear target is the lowest missing index
      tmr_op_type tmr;
   } dp_cmd_type;

   typedef struct packed {
      logic             fill_last;
      logic [CNT_W-1:0] total;
      logic [CNT_W-1:0] low;
      logic             low_hit;
      logic             timer_running;
      logic             timer_expiring;
   } dp_stat_type;

endpackage

FILE: design/param_list_fetch_retransmit_core.sv
// Top level of the parameter list fetch client with retransmission.
// Depends on plfr_pkg, plfr_csr, plfr_ctrl, plfr_datapath, plfr_ram.
//
// Usage: present a transaction on req_* with start high; it is taken at the
// first edge where busy is low. Every transaction produces exactly one result,
// shown on rsp_* for one cycle with rsp_valid high; there is no way to stall
// it, so the receiver must take it then. One transaction is in work at a time:
// busy stays high from the accept until the result is registered, and the
// result is shown in the first cycle with busy low. An ignored value, a tick,
// a list timeout or a timeout with nothing missing goes straight to the
// result; a start also drops the map flags. A timeout that resends an index
// searches for the lowest missing index; a value for an already-known list
// or a timeout that gives up an index also clears a map bit, and searches
// again when the next request needs the new lowest missing index. The first
// value after a start also runs the fill sweep that writes all 32 words of
// the missing map through the single write port of the map RAM. The map
// needs no clearing pass after reset: per-word nonzero flags clear at once.
module param_list_fetch_retransmit_core (
   input  logic                        clock,
   input  logic                        reset,
   // command channel
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_mode,
   input  logic [15:0]                 req_value_index,
   input  logic [15:0]                 req_value_count,
   // result channel
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_request_kind,
   output logic [plfr_pkg::IDX_W-1:0]  rsp_request_index,
   output logic                        rsp_list_done,
   output logic [1:0]                  rsp_phase_now,
   output logic [plfr_pkg::CNT_W-1:0]  rsp_missing_left,
   // configuration port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [plfr_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   logic [3:0]            retry_limit;
   logic [31:0]           timeout_ticks;
   plfr_pkg::dp_cmd_type  dp_cmd;
   plfr_pkg::dp_stat_type dp_stat;

   // Registers: retry budget per request and ticks before a timeout fires.
   plfr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .retry_limit  (retry_limit),
      .timeout_ticks(timeout_ticks)
   );

   // Sequencer: phase, retries and the ordering of map operations.
   plfr_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .mode             (req_mode),
      .retry_limit      (retry_limit),
      .cmd              (dp_cmd),
      .stat             (dp_stat),
      .rsp_valid        (rsp_valid),
      .rsp_request_kind (rsp_request_kind),
      .rsp_request_index(rsp_request_index),
      .rsp_list_done    (rsp_list_done),
      .rsp_phase_now    (rsp_phase_now),
      .rsp_missing_left (rsp_missing_left)
   );

   // Missing map, missing count, lowest-missing search and timeout timer.
   plfr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .value_index  (req_value_index),
      .value_count  (req_value_count),
      .timeout_ticks(timeout_ticks),
      .stat         (dp_stat)
   );

endmodule

FILE: design/plfr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module plfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/plfr_csr.sv
// APB-style configuration registers: retry limit and timeout ticks.
// Depends on plfr_pkg.
module plfr_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [plfr_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output logic [3:0]                  retry_limit,
   output logic [31:0]                 timeout_ticks
);

   logic [3:0]  retry_limit_ff;
   logic [31:0] timeout_ticks_ff;
   logic        reg_sel;
   logic        wr_en;

   assign reg_sel = paddr[2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff   <= plfr_pkg::RETRY_LIMIT_RESET;
         timeout_ticks_ff <= plfr_pkg::TIMEOUT_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            plfr_pkg::REG_RETRY_LIMIT:   retry_limit_ff   <= pwdata[3:0];
            plfr_pkg::REG_TIMEOUT_TICKS: timeout_ticks_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         plfr_pkg::REG_RETRY_LIMIT:   prdata = {28'd0, retry_limit_ff};
         plfr_pkg::REG_TIMEOUT_TICKS: prdata = timeout_ticks_ff;
         default:                     prdata = '0;
      endcase
   end

   assign retry_limit   = retry_limit_ff;
   assign timeout_ticks = timeout_ticks_ff;

endmodule

FILE: design/plfr_datapath.sv
// Datapath: missing map (word RAM plus per-row nonzero flags), missing count,
// lowest-missing search and timeout timer. Depends on plfr_pkg, plfr_ram.
module plfr_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  plfr_pkg::dp_cmd_type  cmd,
   input  logic [15:0]           value_index,
   input  logic [15:0]           value_count,
   input  logic [31:0]           timeout_ticks,
   output plfr_pkg::dp_stat_type stat
);

   localparam int ROWS  = plfr_pkg::ROWS;
   localparam int ROW_W = plfr_pkg::ROW_W;
   localparam int BIT_W = plfr_pkg::BIT_W;
   localparam int IDX_W = plfr_pkg::IDX_W;
   localparam int CNT_W = plfr_pkg::CNT_W;
   localparam int WORD_W = plfr_pkg::WORD_W;
   localparam int HI_W  = CNT_W - BIT_W;

   function automatic logic [ROW_W-1:0] first_row(input logic [ROWS-1:0] v);
      logic [ROW_W-1:0] r;
      r = '0;
      for (int i = ROWS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = ROW_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [BIT_W-1:0] first_bit(input logic [WORD_W-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = BIT_W'(i);
         end
      end
      return r;
   endfunction

   // Row nonzero flags double as row valid bits: a clear flag reads as all zero.
   logic [ROWS-1:0]   row_nz_ff;
   logic [CNT_W-1:0]  total_ff;
   logic [15:0]       vidx_ff;
   logic [15:0]       vcnt_ff;
   logic [CNT_W-1:0]  fill_n_ff;
   logic [ROW_W-1:0]  fill_row_ff;
   logic [ROW_W-1:0]  low_row_ff;
   logic              low_none_ff;
   logic [CNT_W-1:0]  low_ff;
   logic [ROW_W-1:0]  clr_row_ff;
   logic [BIT_W-1:0]  clr_bit_ff;
   logic              clr_ok_ff;
   logic [31:0]       timer_left_ff;
   logic              timer_running_ff;

   logic [CNT_W-1:0]  clamp_n;
   logic [WORD_W-1:0] fill_word;
   logic [HI_W-1:0]   fill_row_ext;
   logic [WORD_W-1:0] rdata;
   logic [WORD_W-1:0] cleared_word;
   logic              clr_hit;
   logic              ram_we;
   logic [ROW_W-1:0]  ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [ROW_W-1:0]  ram_raddr;
   logic [ROW_W-1:0]  clr_row_in;
   logic [BIT_W-1:0]  clr_bit_in;
   logic              clr_range_in;
   logic [IDX_W-1:0]  low_idx;

   // Clamp of the received count into the store
   always_comb begin
      if (vcnt_ff == plfr_pkg::COUNT_UNKNOWN) begin
         clamp_n = '0;
      end else if (vcnt_ff > 16'(plfr_pkg::MAX_PARAMS)) begin
         clamp_n = CNT_W'(plfr_pkg::MAX_PARAMS);
      end else begin
         clamp_n = CNT_W'(vcnt_ff);
      end
   end

   // Fill pattern of one row: all ones below n, zero from n on
   assign fill_row_ext = HI_W'(fill_row_ff);
   always_comb begin
      if (fill_n_ff[CNT_W-1:BIT_W] > fill_row_ext) begin
         fill_word = '1;
      end else if (fill_n_ff[CNT_W-1:BIT_W] == fill_row_ext) begin
         fill_word = (WORD_W'(1) << fill_n_ff[BIT_W-1:0]) - WORD_W'(1);
      end else begin
         fill_word = '0;
      end
   end

   assign low_idx = low_ff[IDX_W-1:0];

   always_comb begin
      if (cmd.sel_low) begin
         clr_row_in   = low_idx[IDX_W-1:BIT_W];
         clr_bit_in   = low_idx[BIT_W-1:0];
         clr_range_in = low_ff < CNT_W'(plfr_pkg::MAX_PARAMS);
      end else begin
         clr_row_in   = vidx_ff[IDX_W-1:BIT_W];
         clr_bit_in   = vidx_ff[BIT_W-1:0];
         clr_range_in = vidx_ff < 16'(plfr_pkg::MAX_PARAMS);
      end
   end

   assign clr_hit      = clr_ok_ff && rdata[clr_bit_ff];
   assign cleared_word = rdata & ~(WORD_W'(1) << clr_bit_ff);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = fill_row_ff;
      ram_wdata = fill_word;
      ram_raddr = first_row(row_nz_ff);
      case (cmd.op)
         plfr_pkg::DP_FILL_STEP: ram_we = 1'b1;
         plfr_pkg::DP_CLR_RD:    ram_raddr = clr_row_in;
         plfr_pkg::DP_CLR_WR: begin
            ram_we    = clr_hit;
            ram_waddr = clr_row_ff;
            ram_wdata = cleared_word;
         end
         default: ;
      endcase
   end

   plfr_ram #(
      .WIDTH(WORD_W),
      .DEPTH(ROWS)
   ) u_map_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_nz_ff        <= '0;
         total_ff         <= '0;
         timer_running_ff <= 1'b0;
         timer_left_ff    <= '0;
      end else begin
         if (cmd.load) begin
            vidx_ff <= value_index;
            vcnt_ff <= value_count;
         end
         case (cmd.op)
            plfr_pkg::DP_CLR_MAP: begin
               row_nz_ff <= '0;
               total_ff  <= '0;
            end
            plfr_pkg::DP_FILL_INIT: begin
               fill_n_ff   <= clamp_n;
               total_ff    <= clamp_n;
               fill_row_ff <= '0;
            end
            plfr_pkg::DP_FILL_STEP: begin
               row_nz_ff[fill_row_ff] <= (fill_word != '0);
               fill_row_ff            <= fill_row_ff + ROW_W'(1);
            end
            plfr_pkg::DP_LOW_RD: begin
               low_row_ff  <= first_row(row_nz_ff);
               low_none_ff <= (row_nz_ff == '0);
            end
            plfr_pkg::DP_LOW_FIN: begin
               if (low_none_ff) begin
                  low_ff <= CNT_W'(plfr_pkg::MAX_PARAMS);
               end else begin
                  low_ff <= CNT_W'({low_row_ff, first_bit(rdata)});
               end
            end
            plfr_pkg::DP_CLR_RD: begin
               clr_row_ff <= clr_row_in;
               clr_bit_ff <= clr_bit_in;
               clr_ok_ff  <= clr_range_in && row_nz_ff[clr_row_in];
            end
            plfr_pkg::DP_CLR_WR: begin
               if (clr_hit) begin
                  row_nz_ff[clr_row_ff] <= (cleared_word != '0);
                  if (total_ff != '0) begin
                     total_ff <= total_ff - CNT_W'(1);
                  end
               end
            end
            default: ;
         endcase
         case (cmd.tmr)
            plfr_pkg::TMR_RESTART: begin
               timer_left_ff    <= timeout_ticks;
               timer_running_ff <= 1'b1;
            end
            plfr_pkg::TMR_DEC:  timer_left_ff <= timer_left_ff - 32'd1;
            plfr_pkg::TMR_STOP: begin
               timer_left_ff    <= '0;
               timer_running_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   assign stat.fill_last      = (fill_row_ff == ROW_W'(ROWS - 1));
   assign stat.total          = total_ff;
   assign stat.low            = low_ff;
   assign stat.low_hit        = (16'(low_ff) == vidx_ff);
   assign stat.timer_running  = timer_running_ff;
   assign stat.timer_expiring = (timer_left_ff[31:1] == '0);

endmodule

FILE: design/plfr_ctrl.sv
// Controller state machine: decodes each transaction, sequences datapath
// operations, keeps phase and retry budget, registers the result.
// Depends on plfr_pkg.
module plfr_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  mode,
   input  logic [3:0]                  retry_limit,
   output plfr_pkg::dp_cmd_type        cmd,
   input  plfr_pkg::dp_stat_type       stat,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_request_kind,
   output logic [plfr_pkg::IDX_W-1:0]  rsp_request_index,
   output logic                        rsp_list_done,
   output logic [1:0]                  rsp_phase_now,
   output logic [plfr_pkg::CNT_W-1:0]  rsp_missing_left
);

   localparam int IDX_W = plfr_pkg::IDX_W;
   localparam int CNT_W = plfr_pkg::CNT_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_CLR_MAP,
      S_FILL_INIT,
      S_FILL,
      S_LOW_RD,
      S_LOW_FIN,
      S_POST,
      S_CLR_RD,
      S_CLR_WR,
      S_RESP
   } state_type;

   // What S_POST continues with
   typedef enum logic [2:0] {
      C_VAL_LOW1,
      C_VAL_CLR,
      C_VAL_LOW2,
      C_TO_LOW1,
      C_TO_CLR,
      C_TO_LOW2
   } ctx_type;

   state_type                state_ff;
   ctx_type                  ctx_ff;
   logic [1:0]               mode_ff;
   logic [1:0]               phase_ff;
   logic [3:0]               retries_ff;
   logic                     first_req_ff;
   logic                     sel_low_ff;
   plfr_pkg::tmr_op_type     tmr_ff;
   logic [1:0]               kind_ff;
   logic [IDX_W-1:0]         ridx_ff;
   logic                     done_ff;
   logic                     rsp_valid_ff;
   logic [1:0]               rsp_kind_ff;
   logic [IDX_W-1:0]         rsp_ridx_ff;
   logic                     rsp_done_ff;
   logic [1:0]               rsp_phase_ff;
   logic [CNT_W-1:0]         rsp_left_ff;
   plfr_pkg::dp_op_type      op;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      case (state_ff)
         S_CLR_MAP:   op = plfr_pkg::DP_CLR_MAP;
         S_FILL_INIT: op = plfr_pkg::DP_FILL_INIT;
         S_FILL:      op = plfr_pkg::DP_FILL_STEP;
         S_LOW_RD:    op = plfr_pkg::DP_LOW_RD;
         S_LOW_FIN:   op = plfr_pkg::DP_LOW_FIN;
         S_CLR_RD:    op = plfr_pkg::DP_CLR_RD;
         S_CLR_WR:    op = plfr_pkg::DP_CLR_WR;
         default:     op = plfr_pkg::DP_NOP;
      endcase
   end

   assign cmd.load    = start && !busy;
   assign cmd.op      = op;
   assign cmd.sel_low = sel_low_ff;
   assign cmd.tmr     = tmr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= plfr_pkg::PH_IDLE;
         retries_ff   <= '0;
         tmr_ff       <= plfr_pkg::TMR_HOLD;
         rsp_valid_ff <= 1'b0;
      end else begin
         tmr_ff       <= plfr_pkg::TMR_HOLD;
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  mode_ff  <= mode;
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               kind_ff  <= plfr_pkg::KIND_NONE;
               ridx_ff  <= '0;
               done_ff  <= 1'b0;
               state_ff <= S_RESP;
               case (mode_ff)
                  plfr_pkg::MODE_START: begin
                     phase_ff   <= plfr_pkg::PH_LIST;
                     retries_ff <= retry_limit;
                     tmr_ff     <= plfr_pkg::TMR_RESTART;
                     kind_ff    <= plfr_pkg::KIND_LIST;
                     state_ff   <= S_CLR_MAP;
                  end
                  plfr_pkg::MODE_VALUE: begin
                     if (phase_ff == plfr_pkg::PH_LIST) begin
                        phase_ff <= plfr_pkg::PH_RECV;
                        state_ff <= S_FILL_INIT;
                     end else if (phase_ff != plfr_pkg::PH_IDLE) begin
                        ctx_ff   <= C_VAL_LOW1;
                        state_ff <= S_LOW_RD;
                     end
                  end
                  plfr_pkg::MODE_TICK: begin
                     if (stat.timer_running) begin
                        if (!stat.timer_expiring) begin
                           tmr_ff <= plfr_pkg::TMR_DEC;
                        end else if (phase_ff == plfr_pkg::PH_LIST) begin
                           if (retries_ff != '0) begin
                              retries_ff <= retries_ff - 4'd1;
                              tmr_ff     <= plfr_pkg::TMR_RESTART;
                              kind_ff    <= plfr_pkg::KIND_LIST;
                           end else begin
                              tmr_ff <= plfr_pkg::TMR_STOP;
                           end
                        end else begin
                           tmr_ff <= plfr_pkg::TMR_STOP;
                           if (phase_ff != plfr_pkg::PH_IDLE) begin
                              if (stat.total == '0) begin
                                 phase_ff <= plfr_pkg::PH_IDLE;
                                 done_ff  <= 1'b1;
                              end else begin
                                 ctx_ff   <= C_TO_LOW1;
                                 state_ff <= S_LOW_RD;
                              end
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
            S_CLR_MAP:   state_ff <= S_RESP;
            S_FILL_INIT: state_ff <= S_FILL;
            S_FILL: begin
               if (stat.fill_last) begin
                  ctx_ff   <= C_VAL_LOW1;
                  state_ff <= S_LOW_RD;
               end
            end
            S_LOW_RD:  state_ff <= S_LOW_FIN;
            S_LOW_FIN: state_ff <= S_POST;
            S_CLR_RD:  state_ff <= S_CLR_WR;
            S_CLR_WR:  state_ff <= S_POST;
            S_POST: begin
               state_ff <= S_RESP;
               case (ctx_ff)
                  C_VAL_LOW1: begin
                     first_req_ff <= (stat.total != '0) && stat.low_hit;
                     sel_low_ff   <= 1'b0;
                     ctx_ff       <= C_VAL_CLR;
                     state_ff     <= S_CLR_RD;
                  end
                  C_VAL_CLR: begin
                     if (first_req_ff) begin
                        retries_ff <= retry_limit;
                     end
                     if (stat.total == '0) begin
                        phase_ff <= plfr_pkg::PH_IDLE;
                        tmr_ff   <= plfr_pkg::TMR_STOP;
                        done_ff  <= 1'b1;
                     end else begin
                        tmr_ff <= plfr_pkg::TMR_RESTART;
                        if (phase_ff == plfr_pkg::PH_RECV_TO) begin
                           ctx_ff   <= C_VAL_LOW2;
                           state_ff <= S_LOW_RD;
                        end
                     end
                  end
                  C_TO_LOW1: begin
                     phase_ff <= plfr_pkg::PH_RECV_TO;
                     if (retries_ff != '0) begin
                        retries_ff <= retries_ff - 4'd1;
                        tmr_ff     <= plfr_pkg::TMR_RESTART;
                        kind_ff    <= plfr_pkg::KIND_ONE;
                        ridx_ff    <= stat.low[IDX_W-1:0];
                     end else begin
                        // budget spent: give up on this index
                        sel_low_ff <= 1'b1;
                        ctx_ff     <= C_TO_CLR;
                        state_ff   <= S_CLR_RD;
                     end
                  end
                  C_TO_CLR: begin
                     tmr_ff <= plfr_pkg::TMR_RESTART;
                     if (stat.total != '0) begin
                        retries_ff <= retry_limit;
                        ctx_ff     <= C_TO_LOW2;
                        state_ff   <= S_LOW_RD;
                     end
                  end
                  default: begin
                     kind_ff <= plfr_pkg::KIND_ONE;
                     ridx_ff <= stat.low[IDX_W-1:0];
                  end
               endcase
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               rsp_kind_ff  <= kind_ff;
               rsp_ridx_ff  <= ridx_ff;
               rsp_done_ff  <= done_ff;
               rsp_phase_ff <= phase_ff;
               rsp_left_ff  <= stat.total;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_request_kind  = rsp_kind_ff;
   assign rsp_request_index = rsp_ridx_ff;
   assign rsp_list_done     = rsp_done_ff;
   assign rsp_phase_now     = rsp_phase_ff;
   assign rsp_missing_left  = rsp_left_ff;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_list_done) |-> (rsp_phase_now == plfr_pkg::PH_IDLE))
      else $error("list done reported outside idle phase");

   a_one_after_timeout: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_request_kind == plfr_pkg::KIND_ONE))
         |-> (rsp_phase_now == plfr_pkg::PH_RECV_TO))
      else $error("single index requested outside timeout receive phase");

endmodule

FILE: bench/param_list_fetch_retransmit_core_test.sv
// Self-checking bench for param_list_fetch_retransmit_core: directed and random
// fetch sessions, with every result checked against a cycle-free list model.
// Depends on plfr_pkg and the core RTL only.
module param_list_fetch_retransmit_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          IDX_W             = plfr_pkg::IDX_W;
   localparam int          CNT_W             = plfr_pkg::CNT_W;
   localparam int          ADDR_W            = plfr_pkg::ADDR_W;
   localparam int          MAX_PARAMS        = plfr_pkg::MAX_PARAMS;
   localparam logic [15:0] COUNT_UNKNOWN     = plfr_pkg::COUNT_UNKNOWN;
   localparam logic [1:0]  MODE_START        = plfr_pkg::MODE_START;
   localparam logic [1:0]  MODE_VALUE        = plfr_pkg::MODE_VALUE;
   localparam logic [1:0]  MODE_TICK         = plfr_pkg::MODE_TICK;
   localparam logic [1:0]  KIND_LIST         = plfr_pkg::KIND_LIST;
   localparam logic [1:0]  KIND_ONE          = plfr_pkg::KIND_ONE;
   localparam logic [1:0]  PH_IDLE           = plfr_pkg::PH_IDLE;
   localparam logic [1:0]  PH_LIST           = plfr_pkg::PH_LIST;
   localparam logic [1:0]  PH_RECV           = plfr_pkg::PH_RECV;
   localparam logic [1:0]  PH_RECV_TO        = plfr_pkg::PH_RECV_TO;
   localparam logic [3:0]  RETRY_LIMIT_RESET = plfr_pkg::RETRY_LIMIT_RESET;
   localparam logic [31:0] TIMEOUT_RESET     = plfr_pkg::TIMEOUT_RESET;

   localparam int                ITEM_TARGET  = 1100;
   localparam int                SETTINGS_CNT = 8;
   localparam logic [1:0]        MODE_UNUSED  = 2'd3;
   localparam logic [ADDR_W-1:0] ADDR_RETRY   = {plfr_pkg::REG_RETRY_LIMIT, 2'b00};
   localparam logic [ADDR_W-1:0] ADDR_TIMEOUT = {plfr_pkg::REG_TIMEOUT_TICKS, 2'b00};

   // one response of the core, packed in port order
   typedef struct packed {
      logic [1:0]       kind;
      logic [IDX_W-1:0] ridx;
      logic             done;
      logic [1:0]       phase;
      logic [CNT_W-1:0] missing;
   } fetch_rsp_type;

   // Tracks the fetch state machine one transaction at a time and holds the
   // responses still owed by the core.
   class list_fetch_tracker_type;
      logic [3:0]            retry_limit;
      logic [31:0]           timeout_ticks;
      logic [1:0]            phase;
      logic [3:0]            retries_left;
      logic [15:0]           expected_count;
      bit [MAX_PARAMS-1:0]   missing_map;
      int                    missing_total;
      logic [31:0]           timer_left;
      bit                    timer_running;
      fetch_rsp_type         owed_rsp[$];
      int                    mismatches;
      int                    n_txn;
      int                    n_list_req;
      int                    n_index_req;
      int                    n_done;

      function new();
         retry_limit    = RETRY_LIMIT_RESET;
         timeout_ticks  = TIMEOUT_RESET;
         phase          = PH_IDLE;
         retries_left   = '0;
         expected_count = '0;
         missing_map    = '0;
         missing_total  = 0;
         timer_left     = '0;
         timer_running  = 0;
      endfunction

      function void write_register(logic [ADDR_W-1:0] addr, logic [31:0] data);
         if (addr == ADDR_RETRY) retry_limit = data[3:0];
         else if (addr == ADDR_TIMEOUT) timeout_ticks = data;
      endfunction

      function int lowest_missing();
         for (int i = 0; i < MAX_PARAMS; i++)
            if (missing_map[i]) return i;
         return MAX_PARAMS;
      endfunction

      function void clear_missing(int idx);
         if (idx < MAX_PARAMS && missing_map[idx]) begin
            missing_map[idx] = 0;
            if (missing_total > 0) missing_total--;
         end
      endfunction

      function void restart_timer();
         timer_left    = timeout_ticks;
         timer_running = 1;
      endfunction

      function void go_idle();
         phase         = PH_IDLE;
         timer_running = 0;
      endfunction

      function int pending();
         return owed_rsp.size();
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH: %s", msg);
      endfunction

      // advance the model by one accepted transaction, queue its response
      function void note_transaction(logic [1:0] mode, logic [15:0] vidx,
                                     logic [15:0] vcnt);
         fetch_rsp_type r;
         int            n;
         int            low;
         bit            first_req;
         r = '0;
         n_txn++;
         case (mode)
            MODE_START: begin
               phase         = PH_LIST;
               retries_left  = retry_limit;
               missing_map   = '0;
               missing_total = 0;
               restart_timer();
               r.kind = KIND_LIST;
            end
            MODE_VALUE: begin
               if (phase != PH_IDLE) begin
                  if (phase == PH_LIST) begin
                     expected_count = vcnt;
                     phase          = PH_RECV;
                     missing_map    = '0;
                     n = 0;
                     if (vcnt != COUNT_UNKNOWN) n = (vcnt > MAX_PARAMS) ? MAX_PARAMS : vcnt;
                     for (int i = 0; i < n; i++) missing_map[i] = 1;
                     missing_total = n;
                  end
                  first_req = (missing_total > 0) && (lowest_missing() == int'(vidx));
                  clear_missing(int'(vidx));
                  if (first_req) retries_left = retry_limit;
                  restart_timer();
                  if (missing_total == 0) begin
                     go_idle();
                     r.done = 1'b1;
                  end else if (phase == PH_RECV_TO) begin
                     r.kind = KIND_ONE;
                     r.ridx = IDX_W'(lowest_missing());
                  end
               end
            end
            MODE_TICK: begin
               if (timer_running) begin
                  if (timer_left > 1) begin
                     timer_left--;
                  end else begin
                     timer_left    = '0;
                     timer_running = 0;
                     if (phase == PH_LIST) begin
                        if (retries_left > 0) begin
                           retries_left--;
                           restart_timer();
                           r.kind = KIND_LIST;
                        end
                     end else if (phase == PH_RECV || phase == PH_RECV_TO) begin
                        if (missing_total == 0) begin
                           go_idle();
                           r.done = 1'b1;
                        end else begin
                           low   = lowest_missing();
                           phase = PH_RECV_TO;
                           if (retries_left > 0) begin
                              retries_left--;
                              restart_timer();
                              r.kind = KIND_ONE;
                              r.ridx = IDX_W'(low);
                           end else begin
                              // budget spent: give up this index, move on
                              clear_missing(low);
                              restart_timer();
                              if (missing_total > 0) begin
                                 retries_left = retry_limit;
                                 r.kind = KIND_ONE;
                                 r.ridx = IDX_W'(lowest_missing());
                              end
                           end
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
         r.phase   = phase;
         r.missing = CNT_W'(missing_total);
         owed_rsp  = {owed_rsp, r};
      endfunction

      function void check_result(fetch_rsp_type got);
         fetch_rsp_type want;
         if (owed_rsp.size() == 0) begin
            report($sformatf("response with nothing owed: kind %0d index %0d done %0d phase %0d missing %0d",
                             got.kind, got.ridx, got.done, got.phase, got.missing));
            return;
         end
         want = owed_rsp[0];
         owed_rsp.delete(0);
         if (want.kind == KIND_LIST) n_list_req++;
         if (want.kind == KIND_ONE) n_index_req++;
         if (want.done) n_done++;
         if (got !== want)
            report($sformatf("expected kind %0d index %0d done %0d phase %0d missing %0d, got kind %0d index %0d done %0d phase %0d missing %0d",
                             want.kind, want.ridx, want.done, want.phase, want.missing,
                             got.kind, got.ridx, got.done, got.phase, got.missing));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_mode;
   logic [15:0]         req_value_index;
   logic [15:0]         req_value_count;
   logic                rsp_valid;
   logic [1:0]          rsp_request_kind;
   logic [IDX_W-1:0]    rsp_request_index;
   logic                rsp_list_done;
   logic [1:0]          rsp_phase_now;
   logic [CNT_W-1:0]    rsp_missing_left;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   list_fetch_tracker_type sb;
   int                  counted;     // transactions presented to the core
   int                  n_settings;

   param_list_fetch_retransmit_core uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_value_index   (req_value_index),
      .req_value_count   (req_value_count),
      .rsp_valid         (rsp_valid),
      .rsp_request_kind  (rsp_request_kind),
      .rsp_request_index (rsp_request_index),
      .rsp_list_done     (rsp_list_done),
      .rsp_phase_now     (rsp_phase_now),
      .rsp_missing_left  (rsp_missing_left),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Monitor: everything here sees pre-edge values, since the core updates
   // its flops with nonblocking assignments. The response is checked before
   // a transaction accepted on the same edge is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_result({rsp_request_kind, rsp_request_index, rsp_list_done,
                             rsp_phase_now, rsp_missing_left});
         if (start && !busy)
            sb.note_transaction(req_mode, req_value_index, req_value_count);
      end
   end

   // Sender idling: light, then heavy, then none, by progress through the run.
   function int idle_pct();
      if (counted < ITEM_TARGET / 3) return 9;
      if (counted < 2 * ITEM_TARGET / 3) return 67;
      return 0;
   endfunction

   // Present one transaction at the falling edge and hold it until an edge
   // with busy low takes it. start stays high into the next call when no
   // gap is drawn, so back-to-back transactions never drop start.
   task automatic send(input logic [1:0] mode, input logic [15:0] vidx,
                       input logic [15:0] vcnt);
      bit taken;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct()) begin
         start = 1'b0;
         @(negedge clock);
      end
      counted++;
      start           = 1'b1;
      req_mode        = mode;
      req_value_index = vidx;
      req_value_count = vcnt;
      taken = 0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
   endtask

   // Drop start and wait until every owed response has come back.
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write, then read back the same register.
   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
      logic [31:0] want;
      want = (addr == ADDR_RETRY) ? {28'd0, data[3:0]} : data;
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      sb.write_register(addr, data);
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      if (prdata !== want)
         sb.report($sformatf("register at %0d read %h, expected %h", addr, prdata, want));
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic configure(input logic [3:0] retry, input logic [31:0] ticks);
      settle();
      csr_write(ADDR_RETRY, {28'd0, retry});
      csr_write(ADDR_TIMEOUT, ticks);
      n_settings++;
   endtask

   // Mostly in-range indices, with a bias toward the lowest missing one so
   // that lists actually complete and retry budgets get refreshed.
   function logic [15:0] pick_index(int n);
      int low;
      low = sb.lowest_missing();
      if (n > 0 && low < MAX_PARAMS && $urandom_range(99) < 25) return 16'(low);
      if (n > 0) return 16'($urandom_range(0, n - 1));
      return 16'($urandom);
   endfunction

   // One well-formed pull: start, optional list timeouts, the first value
   // that sizes the map, then values and ticks with some noise mixed in.
   task automatic list_session();
      logic [15:0] cnt;
      int          n;
      int          roll;
      int          steps;
      send(MODE_START, 16'($urandom), 16'($urandom));
      roll = $urandom_range(99);
      if (roll < 70)      cnt = 16'($urandom_range(1, 20));
      else if (roll < 78) cnt = 16'($urandom_range(21, 64));
      else if (roll < 82) cnt = 16'd0;
      else if (roll < 86) cnt = COUNT_UNKNOWN;
      else if (roll < 90) cnt = 16'(MAX_PARAMS);
      else if (roll < 94) cnt = 16'($urandom_range(MAX_PARAMS + 1, 65534));
      else                cnt = 16'($urandom);
      n = (cnt == COUNT_UNKNOWN) ? 0 : ((cnt > MAX_PARAMS) ? MAX_PARAMS : int'(cnt));
      if ($urandom_range(99) < 30)
         repeat ($urandom_range(1, 6)) send(MODE_TICK, 16'($urandom), 16'($urandom));
      send(MODE_VALUE, pick_index(n), cnt);
      steps = ((n > 40) ? 40 : n) + $urandom_range(0, 6);
      repeat (steps) begin
         roll = $urandom_range(99);
         if (roll < 55)
            send(MODE_VALUE, pick_index(n), 16'($urandom));
         else if (roll < 85)
            send(MODE_TICK, 16'($urandom), 16'($urandom));
         else if (roll < 91)
            send(MODE_VALUE, 16'($urandom_range(MAX_PARAMS, 65535)), 16'($urandom));
         else if (roll < 95)
            send(MODE_UNUSED, 16'($urandom), 16'($urandom));
         else if (roll < 97)
            send(MODE_START, 16'($urandom), 16'($urandom));
         else
            send(MODE_VALUE, 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      sb              = new();
      counted         = 0;
      n_settings      = 0;
      reset           = 1'b1;
      start           = 1'b0;
      req_mode        = MODE_START;
      req_value_index = '0;
      req_value_count = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed ---
      // idle after reset: value ignored, tick with timer stopped, unused mode
      send(MODE_VALUE, 16'd7, 16'd5);
      send(MODE_TICK, 16'd0, 16'd0);
      send(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
      // one retry, zero timeout acting as one tick
      configure(4'd1, 32'd0);
      send(MODE_START, 16'hFFFF, 16'hFFFF);
      send(MODE_TICK, 16'd0, 16'd0);               // list resent
      send(MODE_TICK, 16'd0, 16'd0);               // list retries spent, timer stops
      send(MODE_TICK, 16'd0, 16'd0);               // stopped: nothing
      send(MODE_VALUE, 16'hFFFF, COUNT_UNKNOWN);   // unknown count: done at once
      send(MODE_START, 16'd0, 16'd0);
      send(MODE_VALUE, 16'd0, 16'd0);              // zero count: done at once
      send(MODE_START, 16'd0, 16'd0);
      send(MODE_VALUE, 16'd5, 16'd65534);          // count clamped to store size
      send(MODE_VALUE, 16'd1024, 16'd3);           // index outside the store
      send(MODE_START, 16'd0, 16'd0);              // map cleared on start
      send(MODE_VALUE, 16'd1, 16'd3);
      send(MODE_TICK, 16'd0, 16'd0);               // re-request index 0
      send(MODE_TICK, 16'd0, 16'd0);               // give up 0, ask for 2
      send(MODE_TICK, 16'd0, 16'd0);
      send(MODE_TICK, 16'd0, 16'd0);               // give up 2, map now empty
      send(MODE_TICK, 16'd0, 16'd0);               // empty map on timeout: done
      send(MODE_START, 16'd0, 16'd0);
      send(MODE_VALUE, 16'd0, 16'd2);
      send(MODE_TICK, 16'd0, 16'd0);
      send(MODE_VALUE, 16'd1023, 16'd0);           // after timeout: re-request lowest
      send(MODE_VALUE, 16'd1, COUNT_UNKNOWN);

      // --- random, across several register settings ---
      for (int s = 0; s < SETTINGS_CNT; s++) begin
         case (s)
            0: configure(4'd0, 32'd1);
            1: configure(4'd15, 32'd3);
            2: configure(4'($urandom_range(1, 4)), 32'd0);
            3: configure(4'($urandom), 32'hFFFF_FFFF);
            4: configure(4'd2, 32'($urandom_range(1, 8)));
            5: configure(4'($urandom), 32'($urandom_range(2, 5)));
            6: configure(4'd15, 32'd1);
            default: configure(4'd0, 32'd4);
         endcase
         while (counted < (s + 1) * ITEM_TARGET / SETTINGS_CNT) begin
            if ($urandom_range(9) == 0)
               repeat (6) send(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
            else
               list_session();
         end
      end

      // drain, then give any stray response time to show up
      @(negedge clock);
      start = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("covered %0d transactions under %0d register settings: %0d list and %0d index requests",
               sb.n_txn, n_settings + 1, sb.n_list_req, sb.n_index_req);
      $display("%0d lists completed, %0d mismatches", sb.n_done, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("param_list_fetch_retransmit_core_test passed");
      else
         $display("param_list_fetch_retransmit_core_test failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #(10_000_000);
      $display("param_list_fetch_retransmit_core_test failed");
      $finish;
   end

endmodule

FILE: sim.f
design/plfr_pkg.sv
design/plfr_ram.sv
design/plfr_csr.sv
design/plfr_datapath.sv
design/plfr_ctrl.sv
design/param_list_fetch_retransmit_core.sv
bench/param_list_fetch_retransmit_core_test.sv
